// ===== rtl/core/wmaf_pkg.sv =====
// Shared types, constants and helpers of the three-axis window / exponential smoother.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package wmaf_pkg;

	localparam int WINDOW_MAX = 32;
	localparam int TAP_W      = $clog2(WINDOW_MAX);
	localparam int LEN_W      = TAP_W + 1;
	localparam int AXES       = 3;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_FRAC  = 16;
	localparam int COEF_W     = COEF_FRAC + 1;
	localparam int BETA_W     = 16;
	localparam int EMA_W      = SAMPLE_W + 16;
	localparam int OPND_W     = SAMPLE_W + 1;
	localparam int PROD_W     = COEF_W + 1 + OPND_W;
	localparam int ACC_W      = 52;
	localparam int RND_W      = ACC_W - COEF_FRAC;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_FILTER  = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE = 2'd0,
		REG_LEN  = 2'd1,
		REG_BETA = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_SIMPLE = 2'd0,
		MODE_LINEAR = 2'd1,
		MODE_COSINE = 2'd2,
		MODE_EXP    = 2'd3
	} mode_t;

	// one reading per axis, x in the low slice
	typedef logic [AXES-1:0][SAMPLE_W-1:0] axes_t;

	typedef struct packed {
		logic clr;
		logic fill;
		logic shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic clr;
		logic issue;
		logic shift;
	} mac_ctrl_t;

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [RND_W-1:0] v
	);
		logic signed [RND_W-1:0] hi;
		logic signed [RND_W-1:0] lo;
		hi = RND_W'((2 ** (SAMPLE_W - 1)) - 1);
		lo = -hi - RND_W'(1);
		if (v > hi) begin
			return hi[SAMPLE_W-1:0];
		end else if (v < lo) begin
			return lo[SAMPLE_W-1:0];
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wmaf_ifs.sv =====
// Channel interfaces of the smoother: sample requests, results and register writes.
// Depends on wmaf_pkg for field widths.
`default_nettype none

interface wmaf_smp_if import wmaf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [SAMPLE_W-1:0]  sample_x;
	logic [SAMPLE_W-1:0]  sample_y;
	logic [SAMPLE_W-1:0]  sample_z;
	logic [TAP_W-1:0]     coef_index;
	logic [COEF_W-1:0]    coef_value;

	modport source (output valid, command, sample_x, sample_y, sample_z, coef_index,
		coef_value, input ready);
	modport sink (input valid, command, sample_x, sample_y, sample_z, coef_index,
		coef_value, output ready);
endinterface

interface wmaf_res_if import wmaf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [SAMPLE_W-1:0]  filtered_x;
	logic [SAMPLE_W-1:0]  filtered_y;
	logic [SAMPLE_W-1:0]  filtered_z;

	modport source (output valid, filtered_x, filtered_y, filtered_z, input ready);
	modport sink (input valid, filtered_x, filtered_y, filtered_z, output ready);
endinterface

interface wmaf_cfg_if import wmaf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/weighted_moving_average_filter_3axis_core.sv =====
// Three-axis smoother top level: cell ring, coefficient table, three MAC lanes, sequencer.
// Depends on wmaf_pkg, wmaf_ifs, wmaf_cell and wmaf_mac.
//
// Use: requests arrive on smp (valid/ready). Command filter carries x, y, z and gives one
// result on res; load writes one tap weight; restart clears ring, ring position and the
// exponential state. Neither load nor restart gives a result. The user must write registers
// on cfg (always ready) only while the block is idle; the block does not enforce this.
// Sequencing: a load or restart request leaves the block idle and ready for the next one. In
// a window mode a filter request rotates the 32-cell ring once past one shared multiplier per
// axis in S_SCAN, then passes S_DRAIN and S_FIN into the output register; no new request is
// taken before the block is back in S_IDLE. In exponential mode three products per axis are
// summed in S_EMA_A, S_EMA_B and S_EMA_C, then S_DRAIN, S_FIN and S_FIN2 follow.
// Reset clears ring, weights, state and registers (window length 16); no clearing pass.
// Stall: the result sits in an output register; while res.ready is low the block still
// takes the next request and only waits at the end of that one if the register is full.
`default_nettype none

module weighted_moving_average_filter_3axis_core import wmaf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	wmaf_smp_if.sink   smp,
	wmaf_res_if.source res,
	wmaf_cfg_if.sink   cfg
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EMA_A,
		S_EMA_B,
		S_EMA_C,
		S_DRAIN,
		S_FIN,
		S_FIN2
	} state_t;

	// configuration registers
	logic [1:0]        mode_q;
	logic [LEN_W-1:0]  wlen_q;
	logic [BETA_W-1:0] beta_q;

	// filter state
	state_t                    state_q;
	logic [TAP_W-1:0]          t_q;
	logic [TAP_W-1:0]          base_q;
	logic [LEN_W-1:0]          n_q;
	logic [TAP_W-1:0]          wp_q;
	logic                      primed_q;
	logic [COEF_W-1:0]         coef_q [WINDOW_MAX];
	logic signed [EMA_W-1:0]   prev_q [AXES];
	axes_t                     x_q;
	axes_t                     out_q;
	logic                      ovalid_q;

	// datapath
	axes_t                     smp_axes;
	axes_t                     cell_q [WINDOW_MAX];
	cell_ctrl_t                cell_ctrl;
	logic [WINDOW_MAX-1:0]     cell_wr;
	mac_ctrl_t                 mac_ctrl;
	logic [COEF_W-1:0]         mac_coef;
	logic signed [OPND_W-1:0]  mac_opnd [AXES];
	logic signed [RND_W-1:0]   mac_rnd [AXES];
	logic signed [EMA_W:0]     prev_rnd [AXES];
	axes_t                     win_res;
	axes_t                     ema_res;

	logic                      acc_req;
	logic                      is_exp;
	logic                      do_filter;
	logic                      do_window;
	logic [LEN_W-1:0]          n_use;
	logic [TAP_W-1:0]          wp_eff;
	logic [TAP_W-1:0]          wp_next;
	logic [LEN_W-1:0]          wp_inc;
	logic [LEN_W-1:0]          k_full;
	logic [TAP_W-1:0]          k;
	logic                      tap_ok;
	logic [COEF_W-1:0]         one_m_beta;
	logic                      slot_free;
	logic                      res_load;

	assign smp_axes  = {smp.sample_z, smp.sample_y, smp.sample_x};
	assign smp.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign acc_req   = smp.valid && smp.ready;
	assign is_exp    = (mode_q == MODE_EXP);
	assign do_filter = acc_req && (smp.command == CMD_FILTER);
	assign do_window = do_filter && !is_exp;
	assign slot_free = !ovalid_q || res.ready;
	// a finished result moves into the output register this cycle
	assign res_load  = slot_free && (((state_q == S_FIN) && !is_exp) || (state_q == S_FIN2));

	// clamp window length to 1..WINDOW_MAX
	always_comb begin
		n_use = wlen_q;
		if (wlen_q == '0) begin
			n_use = LEN_W'(1);
		end else if (wlen_q > LEN_W'(WINDOW_MAX)) begin
			n_use = LEN_W'(WINDOW_MAX);
		end
	end

	// restart the ring position when the window shrank below it
	assign wp_eff  = ({1'b0, wp_q} >= n_use) ? '0 : wp_q;
	assign wp_inc  = {1'b0, wp_eff} + LEN_W'(1);
	assign wp_next = (wp_inc >= n_use) ? '0 : wp_inc[TAP_W-1:0];

	// tap age of the slot now at the ring head: slot t against newest slot base
	always_comb begin
		if (t_q <= base_q) begin
			k_full = {1'b0, base_q} - {1'b0, t_q};
		end else begin
			k_full = {1'b0, base_q} + n_q - {1'b0, t_q};
		end
	end
	assign k      = k_full[TAP_W-1:0];
	assign tap_ok = ({1'b0, t_q} < n_q);

	assign one_m_beta = (COEF_W'(1) << COEF_FRAC) - COEF_W'(beta_q);

	// ring control: restart clears, first sample fills, newest sample lands at wp_eff
	always_comb begin
		cell_ctrl.clr   = acc_req && (smp.command == CMD_RESTART);
		cell_ctrl.fill  = do_window && !primed_q;
		cell_ctrl.shift = (state_q == S_SCAN);
		for (int g = 0; g < WINDOW_MAX; g++) begin
			cell_wr[g] = do_window && (wp_eff == TAP_W'(g));
		end
	end

	// each scan cycle moves every cell one place toward the head; a full turn of the ring restores order
	for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
		wmaf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cell_ctrl),
			.wr_sel  (cell_wr[g]),
			.wr_data (smp_axes),
			.nb_data (cell_q[(g + 1) % WINDOW_MAX]),
			.q       (cell_q[g])
		);
	end

	// operand selection for the MAC lanes
	always_comb begin
		mac_ctrl.clr   = do_filter;
		mac_ctrl.issue = (state_q == S_SCAN) || (state_q == S_EMA_A) ||
			(state_q == S_EMA_B) || (state_q == S_EMA_C);
		mac_ctrl.shift = (state_q == S_EMA_A) || (state_q == S_EMA_B);
		mac_coef       = '0;
		for (int a = 0; a < AXES; a++) begin
			mac_opnd[a] = '0;
		end
		case (state_q)
			S_SCAN: begin
				mac_coef = tap_ok ? coef_q[k] : '0;
				for (int a = 0; a < AXES; a++) begin
					mac_opnd[a] = OPND_W'($signed(cell_q[0][a]));
				end
			end
			S_EMA_A: begin
				// (1 - beta) * x, scaled up by 2^16
				mac_coef = one_m_beta;
				for (int a = 0; a < AXES; a++) begin
					mac_opnd[a] = OPND_W'($signed(x_q[a]));
				end
			end
			S_EMA_B: begin
				// beta * integer part of the state, scaled up by 2^16
				mac_coef = COEF_W'(beta_q);
				for (int a = 0; a < AXES; a++) begin
					mac_opnd[a] = OPND_W'($signed(prev_q[a][EMA_W-1 -: SAMPLE_W]));
				end
			end
			S_EMA_C: begin
				// beta * fraction of the state
				mac_coef = COEF_W'(beta_q);
				for (int a = 0; a < AXES; a++) begin
					mac_opnd[a] = OPND_W'({1'b0, prev_q[a][COEF_FRAC-1:0]});
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar a = 0; a < AXES; a++) begin : g_mac
		wmaf_mac u_mac (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (mac_ctrl),
			.coef   (mac_coef),
			.opnd   (mac_opnd[a]),
			.rnd    (mac_rnd[a])
		);
	end

	// final rounding and saturation per axis
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			win_res[a]  = sat_sample(mac_rnd[a]);
			prev_rnd[a] = {prev_q[a][EMA_W-1], prev_q[a]} +
				(EMA_W + 1)'(2 ** (COEF_FRAC - 1));
			ema_res[a]  = sat_sample(RND_W'($signed(prev_rnd[a][EMA_W:COEF_FRAC])));
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SIMPLE;
			wlen_q <= LEN_W'(16);
			beta_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MODE: mode_q <= cfg.data[1:0];
				REG_LEN:  wlen_q <= cfg.data[LEN_W-1:0];
				REG_BETA: beta_q <= cfg.data[BETA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer, filter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			t_q      <= '0;
			base_q   <= '0;
			n_q      <= LEN_W'(1);
			wp_q     <= '0;
			primed_q <= 1'b0;
			x_q      <= '0;
			out_q    <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < WINDOW_MAX; i++) begin
				coef_q[i] <= '0;
			end
			for (int a = 0; a < AXES; a++) begin
				prev_q[a] <= '0;
			end
		end else begin
			// raise valid on a new result, drop it once the receiver takes it
			if (res_load) begin
				ovalid_q <= 1'b1;
			end else if (res.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_req) begin
						case (smp.command)
							CMD_FILTER: begin
								x_q      <= smp_axes;
								primed_q <= 1'b1;
								t_q      <= '0;
								if (is_exp) begin
									// first sample seeds the exponential state
									if (!primed_q) begin
										for (int a = 0; a < AXES; a++) begin
											prev_q[a] <= {smp_axes[a], {(EMA_W - SAMPLE_W){1'b0}}};
										end
									end
									state_q <= S_EMA_A;
								end else begin
									base_q  <= wp_eff;
									n_q     <= n_use;
									wp_q    <= wp_next;
									state_q <= S_SCAN;
								end
							end
							CMD_LOAD: begin
								coef_q[smp.coef_index] <= smp.coef_value;
							end
							CMD_RESTART: begin
								wp_q     <= '0;
								primed_q <= 1'b0;
								for (int a = 0; a < AXES; a++) begin
									prev_q[a] <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					t_q <= t_q + TAP_W'(1);
					if (t_q == TAP_W'(WINDOW_MAX - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_EMA_A: state_q <= S_EMA_B;
				S_EMA_B: state_q <= S_EMA_C;
				S_EMA_C: state_q <= S_DRAIN;
				S_DRAIN: state_q <= S_FIN;
				S_FIN: begin
					if (is_exp) begin
						for (int a = 0; a < AXES; a++) begin
							prev_q[a] <= mac_rnd[a][EMA_W-1:0];
						end
						state_q <= S_FIN2;
					end else if (slot_free) begin
						out_q    <= win_res;
						state_q  <= S_IDLE;
					end
				end
				S_FIN2: begin
					// hold here while the previous result is still waiting
					if (slot_free) begin
						out_q    <= ema_res;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid      = ovalid_q;
	assign res.filtered_x = out_q[0];
	assign res.filtered_y = out_q[1];
	assign res.filtered_z = out_q[2];

endmodule

`default_nettype wire

// ===== rtl/core/wmaf_cell.sv =====
// One history cell: holds the three axis readings of one ring slot.
// Depends on wmaf_pkg; chained into a rotating ring by the top level.
`default_nettype none

module wmaf_cell import wmaf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire logic       wr_sel,
	input  wire axes_t      wr_data,
	input  wire axes_t      nb_data,
	output axes_t           q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (ctrl.clr) begin
			q <= '0;
		end else if (ctrl.fill || wr_sel) begin
			q <= wr_data;
		end else if (ctrl.shift) begin
			q <= nb_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/wmaf_mac.sv =====
// Multiply-accumulate lane for one axis: registered product, wide accumulator, rounding.
// Depends on wmaf_pkg.
`default_nettype none

module wmaf_mac import wmaf_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_ctrl_t                ctrl,
	input  wire logic [COEF_W-1:0]        coef,
	input  wire logic signed [OPND_W-1:0] opnd,
	output logic signed [RND_W-1:0]       rnd
);

	localparam logic signed [ACC_W-1:0] HALF =
		{{(ACC_W - COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};

	logic signed [PROD_W-1:0] prod_s1;
	logic                     issue_s1;
	logic                     shift_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  acc_rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			shift_s1 <= 1'b0;
		end else begin
			issue_s1 <= ctrl.issue;
			shift_s1 <= ctrl.shift;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= $signed({1'b0, coef}) * opnd;
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (issue_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	// scaled terms of the exponential sum enter with a 16-bit shift
	always_comb begin
		addend = ACC_W'(prod_s1);
		if (shift_s1) begin
			addend = addend <<< COEF_FRAC;
		end
	end

	assign acc_rnd = acc_q + HALF;
	assign rnd     = acc_rnd[ACC_W-1 -: RND_W];

endmodule

`default_nettype wire

// ===== rtl/core/wmaf_checker.sv =====
// Port-level checks on the smoother top level, attached by bind.
// Depends on wmaf_pkg and on weighted_moving_average_filter_3axis_core.
`default_nettype none

module wmaf_checker import wmaf_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                smp_valid,
	input wire logic                smp_ready,
	input wire logic [CMD_W-1:0]    smp_command,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire logic [SAMPLE_W-1:0] res_x,
	input wire logic [SAMPLE_W-1:0] res_y,
	input wire logic [SAMPLE_W-1:0] res_z
);

	// a filter request occupies the block: the next request waits
	a_filter_busy: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready && (smp_command == CMD_FILTER) |=> !smp_ready)
		else $error("request taken right after a filter request");

	// load, restart and unused commands do not block the request channel
	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready && (smp_command != CMD_FILTER) |=> smp_ready)
		else $error("short command blocked the request channel");

	// no result can rise in the cycle after a filter request
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready && (smp_command == CMD_FILTER) |=> !$rose(res_valid))
		else $error("result appeared too early");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_x) && $stable(res_y) &&
			$stable(res_z))
		else $error("stalled result changed");

endmodule

bind weighted_moving_average_filter_3axis_core wmaf_checker u_wmaf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.smp_valid   (smp.valid),
	.smp_ready   (smp.ready),
	.smp_command (smp.command),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_x       (res.filtered_x),
	.res_y       (res.filtered_y),
	.res_z       (res.filtered_z)
);

`default_nettype wire
